>>> hw/rtl/rcps_pkg.sv
package rcps_pkg;

    // Set size and derived widths
    localparam int MAX_ELEMENTS = 512;
    localparam int VALUE_W      = 32;
    localparam int PIVOT_W      = 9;
    localparam int IDX_W        = $clog2(MAX_ELEMENTS);
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
    localparam int BAL_W        = IDX_W + 1;
    localparam int CMP_W        = CNT_W + 1;

    // Tercile band: floor(31n/100) .. floor(34n/100), built up one word at a time
    localparam int LO_PCT  = 31;
    localparam int HI_PCT  = 34;
    localparam int PCT_DEN = 100;
    localparam int PCT_W   = $clog2(PCT_DEN);

    typedef enum logic [1:0] {
        MODE_MED_HIGH = 2'd0,
        MODE_MED_LOW  = 2'd1,
        MODE_TER_LOW  = 2'd2,
        MODE_TER_HIGH = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        S_LOAD,
        S_SCAN,
        S_DONE
    } state_t;

    // Per-cycle commands from the controller to every cell
    typedef struct packed {
        logic load;
        logic flush;
    } cell_ctl_t;

    // Stored element moving down the row while a set loads
    typedef struct packed {
        logic                      vld;
        logic signed [VALUE_W-1:0] value;
    } store_t;

    // Candidate with its running rank balance
    typedef struct packed {
        logic                      vld;
        logic signed [VALUE_W-1:0] value;
        logic signed [BAL_W-1:0]   bal;
    } cand_t;

    // Check a finished balance against the selected mode
    function automatic logic accepts(
        input logic signed [BAL_W-1:0] bal,
        input logic [CNT_W-1:0]        lo,
        input logic [CNT_W-1:0]        hi,
        input mode_t                   mode
    );
        logic signed [CMP_W-1:0] balx;
        logic signed [CMP_W-1:0] lox;
        logic signed [CMP_W-1:0] hix;
        logic                    ok;
        balx = CMP_W'(bal);
        lox  = $signed({1'b0, lo});
        hix  = $signed({1'b0, hi});
        case (mode)
            MODE_MED_HIGH: ok = (balx == CMP_W'(0)) || (balx == CMP_W'(1));
            MODE_MED_LOW:  ok = (balx == -CMP_W'(1)) || (balx == CMP_W'(0));
            MODE_TER_LOW:  ok = (balx <= -lox) && (balx >= -hix);
            MODE_TER_HIGH: ok = (balx >= lox) && (balx <= hix);
            default:       ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

>>> hw/rtl/rcps_cell.sv
module rcps_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  rcps_pkg::cell_ctl_t ctl,
    input  rcps_pkg::store_t    sto_in,
    output rcps_pkg::store_t    sto_out,
    input  rcps_pkg::cand_t     cnd_in,
    output rcps_pkg::cand_t     cnd_out
);

    logic                               sto_vld_reg, sto_vld_next;
    logic signed [rcps_pkg::VALUE_W-1:0] sto_value_reg;
    logic                               cnd_vld_reg, cnd_vld_next;
    logic signed [rcps_pkg::VALUE_W-1:0] cnd_value_reg;
    logic signed [rcps_pkg::BAL_W-1:0]   cnd_bal_reg, cnd_bal_next;

    // Shift stored element on load, drop everything on flush
    always_comb begin
        if (ctl.flush) begin
            sto_vld_next = 1'b0;
        end else if (ctl.load) begin
            sto_vld_next = sto_in.vld;
        end else begin
            sto_vld_next = sto_vld_reg;
        end
        cnd_vld_next = cnd_in.vld && !ctl.flush;
    end

    // Add this cell's vote to the passing candidate's balance
    always_comb begin
        cnd_bal_next = cnd_in.bal;
        if (sto_vld_reg && cnd_in.vld) begin
            if ($signed(cnd_in.value) > sto_value_reg) begin
                cnd_bal_next = cnd_in.bal + rcps_pkg::BAL_W'(1);
            end else if ($signed(cnd_in.value) < sto_value_reg) begin
                cnd_bal_next = cnd_in.bal - rcps_pkg::BAL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sto_vld_reg <= 1'b0;
            cnd_vld_reg <= 1'b0;
        end else begin
            sto_vld_reg <= sto_vld_next;
            cnd_vld_reg <= cnd_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            sto_value_reg <= sto_in.value;
        end
        cnd_value_reg <= cnd_in.value;
        cnd_bal_reg   <= cnd_bal_next;
    end

    assign sto_out = '{vld: sto_vld_reg, value: sto_value_reg};
    assign cnd_out = '{vld: cnd_vld_reg, value: cnd_value_reg, bal: cnd_bal_reg};

endmodule

>>> hw/rtl/rcps_ctrl.sv
module rcps_ctrl (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [rcps_pkg::VALUE_W-1:0] s_value,
    input  logic                                s_last,
    input  logic [1:0]                          s_func,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [rcps_pkg::PIVOT_W-1:0]        m_pivot_index,
    output rcps_pkg::cell_ctl_t                 cell_ctl,
    output rcps_pkg::store_t                    sto_head,
    output rcps_pkg::cand_t                     cnd_head,
    input  rcps_pkg::cand_t                     cnd_tail
);

    localparam int SUM_W = rcps_pkg::PCT_W + 1;

    rcps_pkg::state_t state_reg, state_next;
    rcps_pkg::mode_t  mode_reg;

    logic [rcps_pkg::CNT_W-1:0] count_reg, count_next;
    logic [rcps_pkg::CNT_W-1:0] n_reg;
    logic [rcps_pkg::CNT_W-1:0] lo_q_reg, lo_q_next, hi_q_reg, hi_q_next;
    logic [rcps_pkg::PCT_W-1:0] lo_r_reg, lo_r_next, hi_r_reg, hi_r_next;
    logic [SUM_W-1:0]           lo_sum, hi_sum;
    logic [rcps_pkg::IDX_W-1:0] feed_reg, feed_next;
    logic [rcps_pkg::IDX_W-1:0] ex_idx_reg, ex_idx_next;
    logic [rcps_pkg::IDX_W-1:0] res_reg;
    logic [rcps_pkg::IDX_W-1:0] found_idx;
    logic                       rd_vld_reg;
    logic signed [rcps_pkg::VALUE_W-1:0] mem_q_reg;
    logic                       m_valid_reg, m_valid_next;
    logic [rcps_pkg::PIVOT_W-1:0] m_pivot_reg;

    logic signed [rcps_pkg::VALUE_W-1:0] store_mem [rcps_pkg::MAX_ELEMENTS];

    logic accept, do_load, scan_go, full;
    logic in_scan, in_done, out_free;
    logic issue, tail_hit, tail_end, found;
    logic [rcps_pkg::CNT_W-1:0] n_minus1, n_minus2;

    // Handshake and load qualifiers
    assign accept   = s_valid && s_ready;
    assign full     = (count_reg == rcps_pkg::CNT_W'(rcps_pkg::MAX_ELEMENTS));
    assign do_load  = accept && !full;
    assign scan_go  = accept && s_last;
    assign out_free = !m_valid_reg || m_ready;
    assign n_minus1 = n_reg - rcps_pkg::CNT_W'(1);
    assign n_minus2 = n_reg - rcps_pkg::CNT_W'(2);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rcps_pkg::S_LOAD: begin
                if (scan_go) begin
                    state_next = rcps_pkg::S_SCAN;
                end
            end
            rcps_pkg::S_SCAN: begin
                if (found) begin
                    state_next = rcps_pkg::S_DONE;
                end
            end
            rcps_pkg::S_DONE: begin
                if (out_free) begin
                    state_next = rcps_pkg::S_LOAD;
                end
            end
            default: state_next = rcps_pkg::S_LOAD;
        endcase
    end

    // State decode
    always_comb begin
        s_ready = 1'b0;
        in_scan = 1'b0;
        in_done = 1'b0;
        case (state_reg)
            rcps_pkg::S_LOAD: s_ready = 1'b1;
            rcps_pkg::S_SCAN: in_scan = 1'b1;
            rcps_pkg::S_DONE: in_done = 1'b1;
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // Watch the tail of the row; candidates leave in load order
    always_comb begin
        tail_hit  = cnd_tail.vld &&
                    rcps_pkg::accepts(cnd_tail.bal, lo_q_reg, hi_q_reg, mode_reg);
        tail_end  = cnd_tail.vld && (rcps_pkg::CNT_W'(ex_idx_reg) == n_minus2);
        found     = in_scan &&
                    ((n_reg == rcps_pkg::CNT_W'(1)) || tail_hit || tail_end);
        found_idx = tail_hit ? ex_idx_reg : n_minus1[rcps_pkg::IDX_W-1:0];
        issue     = in_scan && !found && (rcps_pkg::CNT_W'(feed_reg) < n_minus1);
    end

    // Element count and tercile bounds as running quotient and remainder
    always_comb begin
        count_next = count_reg;
        lo_q_next  = lo_q_reg;
        lo_r_next  = lo_r_reg;
        hi_q_next  = hi_q_reg;
        hi_r_next  = hi_r_reg;
        lo_sum     = {1'b0, lo_r_reg} + SUM_W'(rcps_pkg::LO_PCT);
        hi_sum     = {1'b0, hi_r_reg} + SUM_W'(rcps_pkg::HI_PCT);
        if (found) begin
            count_next = '0;
            lo_q_next  = '0;
            lo_r_next  = '0;
            hi_q_next  = '0;
            hi_r_next  = '0;
        end else if (do_load) begin
            count_next = count_reg + rcps_pkg::CNT_W'(1);
            if (lo_sum >= SUM_W'(rcps_pkg::PCT_DEN)) begin
                lo_r_next = rcps_pkg::PCT_W'(lo_sum - SUM_W'(rcps_pkg::PCT_DEN));
                lo_q_next = lo_q_reg + rcps_pkg::CNT_W'(1);
            end else begin
                lo_r_next = lo_sum[rcps_pkg::PCT_W-1:0];
            end
            if (hi_sum >= SUM_W'(rcps_pkg::PCT_DEN)) begin
                hi_r_next = rcps_pkg::PCT_W'(hi_sum - SUM_W'(rcps_pkg::PCT_DEN));
                hi_q_next = hi_q_reg + rcps_pkg::CNT_W'(1);
            end else begin
                hi_r_next = hi_sum[rcps_pkg::PCT_W-1:0];
            end
        end
    end

    // Feed and exit counters
    always_comb begin
        feed_next   = feed_reg;
        ex_idx_next = ex_idx_reg;
        if (scan_go) begin
            feed_next   = '0;
            ex_idx_next = '0;
        end else begin
            if (issue) begin
                feed_next = feed_reg + rcps_pkg::IDX_W'(1);
            end
            if (in_scan && cnd_tail.vld) begin
                ex_idx_next = ex_idx_reg + rcps_pkg::IDX_W'(1);
            end
        end
    end

    // Output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (in_done && out_free) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rcps_pkg::S_LOAD;
            count_reg   <= '0;
            lo_q_reg    <= '0;
            lo_r_reg    <= '0;
            hi_q_reg    <= '0;
            hi_r_reg    <= '0;
            feed_reg    <= '0;
            ex_idx_reg  <= '0;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            lo_q_reg    <= lo_q_next;
            lo_r_reg    <= lo_r_next;
            hi_q_reg    <= hi_q_next;
            hi_r_reg    <= hi_r_next;
            feed_reg    <= feed_next;
            ex_idx_reg  <= ex_idx_next;
            rd_vld_reg  <= issue;
            m_valid_reg <= m_valid_next;
        end
    end

    // Hold set size and mode for the scan, latch the chosen index
    always_ff @(posedge aclk) begin
        if (scan_go) begin
            n_reg    <= count_next;
            mode_reg <= rcps_pkg::mode_t'(s_func);
        end
        if (found) begin
            res_reg <= found_idx;
        end
        if (in_done && out_free) begin
            m_pivot_reg <= rcps_pkg::PIVOT_W'(res_reg);
        end
    end

    // Candidate store: write in load order, read one candidate a cycle
    always_ff @(posedge aclk) begin
        if (do_load) begin
            store_mem[count_reg[rcps_pkg::IDX_W-1:0]] <= s_value;
        end
        mem_q_reg <= store_mem[feed_reg];
    end

    assign cell_ctl      = '{load: do_load, flush: found};
    assign sto_head      = '{vld: 1'b1, value: s_value};
    assign cnd_head      = '{vld: rd_vld_reg, value: mem_q_reg, bal: '0};
    assign m_valid       = m_valid_reg;
    assign m_pivot_index = m_pivot_reg;

endmodule

>>> hw/rtl/rank_count_pivot_select_top.sv
// Channel | Ports                           | Word
// --------+---------------------------------+-------------------------------------
// input   | s_valid s_ready                 | s_value[31:0] s_last s_func[1:0]
// result  | m_valid m_ready                 | m_pivot_index[8:0]
//
// Loading takes one word per cycle into the row of 512 cells; reset is synchronous.
// After the last word, candidates reach the row's end in load order, and the result
// register takes the first accepted index; a full miss returns index n - 1.
// The cell row length sets the scan time; the candidate store needs no clearing.
// The result waits in an output register while the next set loads; a later
// selection holds until that register is free.
module rank_count_pivot_select_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [rcps_pkg::VALUE_W-1:0] s_value,
    input  logic                                s_last,
    input  logic [1:0]                          s_func,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [rcps_pkg::PIVOT_W-1:0]        m_pivot_index
);

    rcps_pkg::cell_ctl_t cell_ctl;
    rcps_pkg::store_t    sto_head;
    rcps_pkg::cand_t     cnd_head;
    rcps_pkg::store_t    sto_chain [rcps_pkg::MAX_ELEMENTS];
    rcps_pkg::cand_t     cnd_chain [rcps_pkg::MAX_ELEMENTS];

    rcps_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_value       (s_value),
        .s_last        (s_last),
        .s_func        (s_func),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pivot_index (m_pivot_index),
        .cell_ctl      (cell_ctl),
        .sto_head      (sto_head),
        .cnd_head      (cnd_head),
        .cnd_tail      (cnd_chain[rcps_pkg::MAX_ELEMENTS-1])
    );

    // Row of rank cells: stored words shift down, candidates stream through
    for (genvar k = 0; k < rcps_pkg::MAX_ELEMENTS; k++) begin : g_cell
        if (k == 0) begin : g_first
            rcps_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctl     (cell_ctl),
                .sto_in  (sto_head),
                .sto_out (sto_chain[k]),
                .cnd_in  (cnd_head),
                .cnd_out (cnd_chain[k])
            );
        end else begin : g_next
            rcps_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctl     (cell_ctl),
                .sto_in  (sto_chain[k-1]),
                .sto_out (sto_chain[k]),
                .cnd_in  (cnd_chain[k-1]),
                .cnd_out (cnd_chain[k])
            );
        end
    end

endmodule

>>> hw/rtl/rcps_checker.sv
module rcps_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic signed [rcps_pkg::VALUE_W-1:0] s_value,
    input logic                                s_last,
    input logic [1:0]                          s_func,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic [rcps_pkg::PIVOT_W-1:0]        m_pivot_index
);

    // Closing word starts a scan, so input stalls next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_last |=> !s_ready)
        else $error("input still ready after closing word");

    // Stalled result word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pivot_index))
        else $error("result word changed while stalled");

    // A result appears only after a scan has held the input
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result word without a finished scan");

    // Reset drops any pending result
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind rank_count_pivot_select_top rcps_checker u_checker (.*);
